// ----- design/affine_6d_transform_unit_defines.svh -----
// Assertion macros for the affine transform unit
`ifndef AFFINE_6D_TRANSFORM_UNIT_DEFINES_SVH
`define AFFINE_6D_TRANSFORM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define A6T_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define A6T_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define A6T_IMPLIES(lbl, ante, cons)
`define A6T_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/a6t_pkg.sv -----
package a6t_pkg;

    localparam int STEP_W = 4;
    localparam int TRIG_LAST = 11;
    localparam logic [31:0] ONE30 = 32'h4000_0000;
    localparam logic [31:0] K4 = 32'd1686629713;

    typedef enum logic [2:0] {
        FN_IDENT = 3'd0,
        FN_ROT   = 3'd1,
        FN_LOAD  = 3'd2,
        FN_MUL   = 3'd3,
        FN_READ  = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDENT,
        ST_LOAD,
        ST_TMUL,
        ST_TRND,
        ST_TDIV,
        ST_TWB,
        ST_QUAD,
        ST_ROT,
        ST_MAC,
        ST_MWB,
        ST_RD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SA_U,
        SA_X,
        SA_X2
    } src_a_t;

    typedef enum logic [2:0] {
        SB_K4,
        SB_X,
        SB_ONE,
        SB_P,
        SB_Q
    } src_b_t;

    typedef enum logic [2:0] {
        DT_X,
        DT_X2,
        DT_P,
        DT_Q,
        DT_S0,
        DT_C0
    } dest_t;

    // recip is ceil(2^rshift / divisor); zero means no division
    typedef struct packed {
        src_a_t      a_sel;
        src_b_t      b_sel;
        logic        shift14;
        logic [31:0] recip;
        logic [5:0]  rshift;
        logic        sub_one;
        dest_t       dest;
    } trig_op_t;

    function automatic trig_op_t trig_op(input logic [3:0] tp);
        trig_op_t op;
        op = '{SA_X2, SB_Q, 1'b0, 32'd0, 6'd0, 1'b0, DT_C0};
        unique case (tp)
            4'd0:    op = '{SA_U,  SB_K4,  1'b1, 32'd0,          6'd0,  1'b0, DT_X};
            4'd1:    op = '{SA_X,  SB_X,   1'b0, 32'd0,          6'd0,  1'b0, DT_X2};
            4'd2:    op = '{SA_X2, SB_ONE, 1'b0, 32'd1908874354, 6'd37, 1'b1, DT_P};
            4'd3:    op = '{SA_X2, SB_ONE, 1'b0, 32'd1527099484, 6'd37, 1'b1, DT_Q};
            4'd4:    op = '{SA_X2, SB_P,   1'b0, 32'd1636178018, 6'd36, 1'b1, DT_P};
            4'd5:    op = '{SA_X2, SB_P,   1'b0, 32'd1717986919, 6'd35, 1'b1, DT_P};
            4'd6:    op = '{SA_X2, SB_P,   1'b0, 32'd1431655766, 6'd33, 1'b1, DT_P};
            4'd7:    op = '{SA_X,  SB_P,   1'b0, 32'd0,          6'd0,  1'b0, DT_S0};
            4'd8:    op = '{SA_X2, SB_Q,   1'b0, 32'd1227133514, 6'd36, 1'b1, DT_Q};
            4'd9:    op = '{SA_X2, SB_Q,   1'b0, 32'd1145324613, 6'd35, 1'b1, DT_Q};
            4'd10:   op = '{SA_X2, SB_Q,   1'b0, 32'd1431655766, 6'd34, 1'b1, DT_Q};
            4'd11:   op = '{SA_X2, SB_Q,   1'b0, 32'd1073741824, 6'd31, 1'b1, DT_C0};
            default: op = '{SA_X2, SB_Q,   1'b0, 32'd0,          6'd0,  1'b0, DT_C0};
        endcase
        return op;
    endfunction

endpackage

// ----- design/affine_6d_transform_unit.sv -----
// Operations: identity, load, read and unused codes, rotate (12 sine steps, then one
// column at a time), rotate with bad rows, and multiply (one shared multiplier).
// One item at a time: busy is high from the transfer until done pulses.
// Reset: asynchronous, active low; then a sweep writes the identity matrix while
// busy is high. The receiver cannot stall done.
`include "affine_6d_transform_unit_defines.svh"

module affine_6d_transform_unit
    import a6t_pkg::*;
#(
    parameter int DIMENSIONS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [2:0]         func,
    input  logic [2:0]         first_row,
    input  logic [2:0]         second_row,
    input  logic [15:0]        angle,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [31:0] value,
    output logic signed [31:0] element,
    output logic               saturated
);

    localparam int COLS = DIMENSIONS + 1;
    localparam int DEPTH = DIMENSIONS * COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DIMENSIONS + 2);
    localparam int RW = $clog2(DIMENSIONS);
    localparam int ACC_W = 64 + $clog2(DIMENSIONS + 1) + 1;
    localparam logic signed [ACC_W-1:0] HALF_F = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_T = {{(ACC_W-1){1'b0}}, 1'b1} << 29;
    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-32){1'b1}}, 32'h8000_0000};
    localparam logic [31:0] ONE_F = 32'(64'd1 << FRAC_BITS);

    function automatic logic [AW-1:0] addr_of(input int r, input int c);
        return AW'(r * COLS + c);
    endfunction

    state_t state_reg, state_next;
    logic init_reg, init_next;
    logic done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [3:0] tp_reg, tp_next;
    logic [4:0] dc_reg, dc_next;
    logic [CW-1:0] ri_reg, ri_next, ci_reg, ci_next;
    logic sat_reg, sat_next;

    logic [2:0] func_reg, func_next, frow_reg, frow_next, srow_reg, srow_next;
    logic [2:0] row_reg, row_next, col_reg, col_next;
    logic [15:0] angle_reg, angle_next;
    logic signed [31:0] value_reg, value_next;
    logic [31:0] x_reg, x_next, x2_reg, x2_next, p_reg, p_next, q_reg, q_next;
    logic [31:0] s0_reg, s0_next, c0_reg, c0_next, tv_reg, tv_next;
    logic signed [31:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0] colbuf_reg [DIMENSIONS];
    logic signed [31:0] colbuf_next [DIMENSIONS];
    logic signed [31:0] element_reg, element_next;
    logic saturated_reg, saturated_next;

    logic signed [31:0] tmem [DEPTH];
    logic signed [31:0] rmem [DEPTH];
    logic signed [31:0] t_rdata_reg, r_rdata_reg;
    logic t_we, r_we;
    logic [AW-1:0] t_waddr, t_raddr, r_waddr, r_raddr;
    logic signed [31:0] t_wdata, r_wdata;

    logic signed [31:0] mul_a, mul_b;
    logic fin_trig, fin_sat;
    logic signed [ACC_W-1:0] fin_rnd;
    logic signed [31:0] fin_val;
    trig_op_t op;
    logic [13:0] ang_r;
    logic [14:0] u_val;
    logic [63:0] prod_u;
    logic [31:0] twb_val;
    logic signed [31:0] cc, ss;
    logic idx_ok;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign element = element_reg;
    assign saturated = saturated_reg;

    assign idx_ok = (int'(row_reg) < DIMENSIONS) && (int'(col_reg) <= DIMENSIONS);
    assign op = trig_op(tp_reg);
    assign ang_r = angle_reg[13:0];
    assign u_val = (ang_r <= 14'd8192) ? {1'b0, ang_r} : 15'(15'd16384 - {1'b0, ang_r});
    assign prod_u = prod_reg;
    assign twb_val = op.sub_one ? (ONE30 - tv_reg) : tv_reg;

    always_comb
    begin
        fin_rnd = fin_trig ? ((acc_reg + HALF_T) >>> 30) : ((acc_reg + HALF_F) >>> FRAC_BITS);
        fin_sat = (fin_rnd > SAT_MAX) || (fin_rnd < SAT_MIN);
        if (fin_rnd > SAT_MAX)
        begin
            fin_val = 32'sh7fff_ffff;
        end
        else if (fin_rnd < SAT_MIN)
        begin
            fin_val = 32'sh8000_0000;
        end
        else
        begin
            fin_val = fin_rnd[31:0];
        end
    end

    always_comb
    begin
        if (ang_r > 14'd8192)
        begin
            cc = s0_reg;
            ss = c0_reg;
        end
        else
        begin
            cc = c0_reg;
            ss = s0_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        init_next = init_reg;
        done_next = 1'b0;
        step_next = step_reg;
        tp_next = tp_reg;
        dc_next = dc_reg;
        ri_next = ri_reg;
        ci_next = ci_reg;
        sat_next = sat_reg;
        func_next = func_reg;
        frow_next = frow_reg;
        srow_next = srow_reg;
        row_next = row_reg;
        col_next = col_reg;
        angle_next = angle_reg;
        value_next = value_reg;
        x_next = x_reg;
        x2_next = x2_reg;
        p_next = p_reg;
        q_next = q_reg;
        s0_next = s0_reg;
        c0_next = c0_reg;
        tv_next = tv_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        colbuf_next = colbuf_reg;
        element_next = element_reg;
        saturated_next = saturated_reg;
        t_we = 1'b0;
        t_waddr = '0;
        t_wdata = '0;
        t_raddr = '0;
        r_we = 1'b0;
        r_waddr = '0;
        r_wdata = '0;
        r_raddr = '0;
        mul_a = '0;
        mul_b = '0;
        fin_trig = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    frow_next = first_row;
                    srow_next = second_row;
                    angle_next = angle;
                    row_next = row;
                    col_next = col;
                    value_next = value;
                    sat_next = 1'b0;
                    ri_next = '0;
                    ci_next = '0;
                    step_next = '0;
                    tp_next = '0;
                    unique case (func)
                        FN_IDENT: state_next = ST_IDENT;
                        FN_LOAD:  state_next = ST_LOAD;
                        FN_MUL:   state_next = ST_MAC;
                        FN_ROT:
                        begin
                            if ((int'(first_row) < DIMENSIONS) && (int'(second_row) < DIMENSIONS)
                                && (first_row != second_row))
                            begin
                                state_next = ST_TMUL;
                            end
                            else
                            begin
                                state_next = ST_RD;
                            end
                        end
                        default:  state_next = ST_RD;
                    endcase
                end
            end
            ST_IDENT:
            begin
                t_we = 1'b1;
                t_waddr = addr_of(int'(ri_reg), int'(ci_reg));
                t_wdata = (ri_reg == ci_reg) ? ONE_F : 32'sd0;
                if (ci_reg == CW'(DIMENSIONS))
                begin
                    ci_next = '0;
                    if (ri_reg == CW'(DIMENSIONS - 1))
                    begin
                        ri_next = '0;
                        init_next = 1'b0;
                        state_next = init_reg ? ST_IDLE : ST_RD;
                    end
                    else
                    begin
                        ri_next = ri_reg + 1'b1;
                    end
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                r_we = idx_ok;
                r_waddr = addr_of(int'(row_reg), int'(col_reg));
                r_wdata = value_reg;
                state_next = ST_RD;
            end
            ST_TMUL:
            begin
                unique case (op.a_sel)
                    SA_U:    mul_a = 32'(u_val);
                    SA_X:    mul_a = x_reg;
                    default: mul_a = x2_reg;
                endcase
                unique case (op.b_sel)
                    SB_K4:   mul_b = K4;
                    SB_X:    mul_b = x_reg;
                    SB_ONE:  mul_b = ONE30;
                    SB_P:    mul_b = p_reg;
                    default: mul_b = q_reg;
                endcase
                state_next = ST_TRND;
            end
            ST_TRND:
            begin
                tv_next = op.shift14 ? 32'(prod_u >> 14) : 32'((prod_u + 64'd536870912) >> 30);
                dc_next = '0;
                state_next = (op.recip != 32'd0) ? ST_TDIV : ST_TWB;
            end
            ST_TDIV:
            begin
                if (dc_reg == 5'd0)
                begin
                    mul_a = tv_reg;
                    mul_b = op.recip;
                    dc_next = 5'd1;
                end
                else
                begin
                    tv_next = 32'(prod_u >> op.rshift);
                    state_next = ST_TWB;
                end
            end
            ST_TWB:
            begin
                unique case (op.dest)
                    DT_X:    x_next = twb_val;
                    DT_X2:   x2_next = twb_val;
                    DT_P:    p_next = twb_val;
                    DT_Q:    q_next = twb_val;
                    DT_S0:   s0_next = twb_val;
                    default: c0_next = twb_val;
                endcase
                if (tp_reg == 4'(TRIG_LAST))
                begin
                    state_next = ST_QUAD;
                end
                else
                begin
                    tp_next = tp_reg + 1'b1;
                    state_next = ST_TMUL;
                end
            end
            ST_QUAD:
            begin
                unique case (angle_reg[15:14])
                    2'd0:
                    begin
                        cos_next = cc;
                        sin_next = ss;
                    end
                    2'd1:
                    begin
                        cos_next = -ss;
                        sin_next = cc;
                    end
                    2'd2:
                    begin
                        cos_next = -cc;
                        sin_next = -ss;
                    end
                    default:
                    begin
                        cos_next = ss;
                        sin_next = -cc;
                    end
                endcase
                ci_next = '0;
                step_next = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    4'd0: t_raddr = addr_of(int'(frow_reg), int'(ci_reg));
                    4'd1:
                    begin
                        a_next = t_rdata_reg;
                        t_raddr = addr_of(int'(srow_reg), int'(ci_reg));
                    end
                    4'd2: b_next = t_rdata_reg;
                    4'd3:
                    begin
                        mul_a = a_reg;
                        mul_b = cos_reg;
                    end
                    4'd4:
                    begin
                        acc_next = ACC_W'(prod_reg);
                        mul_a = b_reg;
                        mul_b = sin_reg;
                    end
                    4'd5:
                    begin
                        acc_next = acc_reg + ACC_W'(prod_reg);
                        mul_a = b_reg;
                        mul_b = cos_reg;
                    end
                    4'd6:
                    begin
                        fin_trig = 1'b1;
                        t_we = 1'b1;
                        t_waddr = addr_of(int'(frow_reg), int'(ci_reg));
                        t_wdata = fin_val;
                        sat_next = sat_reg | fin_sat;
                        acc_next = ACC_W'(prod_reg);
                        mul_a = a_reg;
                        mul_b = sin_reg;
                    end
                    4'd7: acc_next = acc_reg - ACC_W'(prod_reg);
                    default:
                    begin
                        fin_trig = 1'b1;
                        t_we = 1'b1;
                        t_waddr = addr_of(int'(srow_reg), int'(ci_reg));
                        t_wdata = fin_val;
                        sat_next = sat_reg | fin_sat;
                        step_next = '0;
                        if (ci_reg == CW'(DIMENSIONS))
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            ci_next = ci_reg + 1'b1;
                        end
                    end
                endcase
            end
            ST_MAC:
            begin
                step_next = step_reg + 1'b1;
                mul_a = r_rdata_reg;
                mul_b = t_rdata_reg;
                if (int'(step_reg) < DIMENSIONS)
                begin
                    t_raddr = addr_of(int'(step_reg), int'(ci_reg));
                    r_raddr = addr_of(int'(ri_reg), int'(step_reg));
                end
                else
                begin
                    r_raddr = addr_of(int'(ri_reg), DIMENSIONS);
                end
                if (step_reg == STEP_W'(2))
                begin
                    acc_next = ACC_W'(prod_reg);
                end
                else if ((step_reg > STEP_W'(2)) && (int'(step_reg) <= DIMENSIONS + 1))
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                else if (step_reg == STEP_W'(DIMENSIONS + 2))
                begin
                    if (ci_reg == CW'(DIMENSIONS))
                    begin
                        acc_next = acc_reg + (ACC_W'(r_rdata_reg) <<< FRAC_BITS);
                    end
                end
                else if (step_reg == STEP_W'(DIMENSIONS + 3))
                begin
                    colbuf_next[ri_reg[RW-1:0]] = fin_val;
                    sat_next = sat_reg | fin_sat;
                    step_next = '0;
                    if (ri_reg == CW'(DIMENSIONS - 1))
                    begin
                        ri_next = '0;
                        state_next = ST_MWB;
                    end
                    else
                    begin
                        ri_next = ri_reg + 1'b1;
                    end
                end
            end
            ST_MWB:
            begin
                t_we = 1'b1;
                t_waddr = addr_of(int'(ri_reg), int'(ci_reg));
                t_wdata = colbuf_reg[ri_reg[RW-1:0]];
                if (ri_reg == CW'(DIMENSIONS - 1))
                begin
                    ri_next = '0;
                    step_next = '0;
                    if (ci_reg == CW'(DIMENSIONS))
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        ci_next = ci_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
                else
                begin
                    ri_next = ri_reg + 1'b1;
                end
            end
            ST_RD:
            begin
                t_raddr = idx_ok ? addr_of(int'(row_reg), int'(col_reg)) : '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                element_next = idx_ok ? t_rdata_reg : 32'sd0;
                saturated_next = sat_reg;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDENT;
            init_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            tp_reg <= '0;
            dc_reg <= '0;
            ri_reg <= '0;
            ci_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg <= init_next;
            done_reg <= done_next;
            step_reg <= step_next;
            tp_reg <= tp_next;
            dc_reg <= dc_next;
            ri_reg <= ri_next;
            ci_reg <= ci_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        frow_reg <= frow_next;
        srow_reg <= srow_next;
        row_reg <= row_next;
        col_reg <= col_next;
        angle_reg <= angle_next;
        value_reg <= value_next;
        x_reg <= x_next;
        x2_reg <= x2_next;
        p_reg <= p_next;
        q_reg <= q_next;
        s0_reg <= s0_next;
        c0_reg <= c0_next;
        tv_reg <= tv_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
        a_reg <= a_next;
        b_reg <= b_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        colbuf_reg <= colbuf_next;
        element_reg <= element_next;
        saturated_reg <= saturated_next;
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[t_waddr] <= t_wdata;
        end
        t_rdata_reg <= tmem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rmem[r_waddr] <= r_wdata;
        end
        r_rdata_reg <= rmem[r_raddr];
    end

    `A6T_NEXT(a_done_pulse, done_reg, !done_reg)
    `A6T_NEXT(a_busy_after_start, start && !busy, busy)
    `A6T_IMPLIES(a_sat_ops, state_reg == ST_OUT && func_reg != FN_ROT && func_reg != FN_MUL, !sat_reg)
    `A6T_NEXT(a_bad_idx_zero, state_reg == ST_OUT && !idx_ok, element == 32'sd0)

endmodule
